// ===== src/sgd_momentum_update_unit_assert.svh =====
// Assertion macros used by the update unit front end (smu_front)
`ifndef SGD_MOMENTUM_UPDATE_UNIT_ASSERT_SVH
`define SGD_MOMENTUM_UPDATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define SMU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smu assertion failed");
// next-cycle implication
`define SMU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smu assertion failed");
`else
`define SMU_ASSERT_NOW(label, ante, cons)
`define SMU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/smu_pkg.sv =====
// Types, constants and fixed-point helpers of the SGD momentum update unit
package smu_pkg;

    localparam int VAL_W      = 32;
    localparam int IDX_W      = 12;
    localparam int COEF_W     = 17;
    localparam int COEF_SHIFT = 16;
    localparam int PROD_W     = VAL_W + COEF_W + 1;
    localparam int MEM_W      = VAL_W + 1;

    localparam int unsigned MAX_ELEMENTS_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPENING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NESTEROV      = 3'd4;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [COEF_W-1:0]        coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam coef_t LR_RESET  = 17'd655;
    localparam coef_t COEF_ONE  = 17'd65536;
    localparam val_t  VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t  VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam prod_t ROUND_HALF = prod_t'(2 ** (COEF_SHIFT - 1));

    typedef struct packed {
        coef_t learning_rate;
        coef_t decay;
        coef_t momentum;
        coef_t dampening;
        logic  nesterov;
    } cfg_t;

    // value with its clamp flag
    typedef struct packed {
        logic clamp;
        val_t val;
    } sval_t;

    // what the momentum half hands to the step half
    typedef struct packed {
        val_t theta;
        val_t d;
        val_t mbuf;
        logic clamp;
    } upd_t;

    function automatic prod_t coef_mul(input coef_t c, input val_t v);
        return $signed({1'b0, c}) * v;
    endfunction

    // product / 65536, round half up, clamp to value range
    function automatic sval_t round_sat(input prod_t p);
        prod_t s;
        prod_t q;
        logic [PROD_W-VAL_W:0] hi;
        sval_t r;
        s  = p + ROUND_HALF;
        q  = s >>> COEF_SHIFT;
        hi = q[PROD_W-1:VAL_W-1];
        if (hi == '0 || hi == '1)
        begin
            r.clamp = 1'b0;
            r.val   = q[VAL_W-1:0];
        end
        else
        begin
            r.clamp = 1'b1;
            r.val   = q[PROD_W-1] ? VAL_MIN : VAL_MAX;
        end
        return r;
    endfunction

    function automatic sval_t add_sat(input val_t a, input val_t b, input logic sub);
        logic [VAL_W:0] s;
        sval_t r;
        if (sub)
            s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        else
            s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
        begin
            r.clamp = 1'b1;
            r.val   = s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            r.clamp = 1'b0;
            r.val   = s[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/smu_if.sv =====
// Item and result channel interfaces
interface smu_in_if;
    logic                               valid;
    logic                               ready;
    logic [smu_pkg::IDX_W-1:0]          element_index;
    logic signed [smu_pkg::VAL_W-1:0]   param_value;
    logic signed [smu_pkg::VAL_W-1:0]   grad_value;

    modport source (output valid, element_index, param_value, grad_value, input ready);
    modport sink   (input valid, element_index, param_value, grad_value, output ready);
endinterface

interface smu_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [smu_pkg::VAL_W-1:0]   new_param;
    logic signed [smu_pkg::VAL_W-1:0]   momentum_out;
    logic                               saturated;

    modport source (output valid, new_param, momentum_out, saturated, input ready);
    modport sink   (input valid, new_param, momentum_out, saturated, output ready);
endinterface

// ===== src/smu_ram.sv =====
// Momentum store: one write port, one registered read port
module smu_ram #(
    parameter int unsigned DEPTH  = smu_pkg::MAX_ELEMENTS_DEF,
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned DATA_W = smu_pkg::MEM_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/smu_front.sv =====
// Stages 1-4: weight decay, momentum read, buffer update and write-back
`include "sgd_momentum_update_unit_assert.svh"

module smu_front #(
    parameter int unsigned MAX_ELEMENTS = smu_pkg::MAX_ELEMENTS_DEF,
    parameter int unsigned ADDR_W       = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  smu_pkg::cfg_t             cfg,
    input  logic                      hold,
    smu_in_if.sink                    item,
    output logic                      mem_re,
    output logic [ADDR_W-1:0]         mem_raddr,
    input  logic [smu_pkg::MEM_W-1:0] mem_rdata,
    output logic                      mem_we,
    output logic [ADDR_W-1:0]         mem_waddr,
    output logic [smu_pkg::MEM_W-1:0] mem_wdata,
    output logic                      upd_valid,
    input  logic                      upd_ready,
    output smu_pkg::upd_t             upd
);
    import smu_pkg::*;

    localparam int unsigned EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    // stage 1
    logic              v1_reg;
    logic [ADDR_W-1:0] a1_reg;
    val_t              theta1_reg;
    val_t              g1_reg;
    // stage 2
    logic              v2_reg;
    logic [ADDR_W-1:0] a2_reg;
    val_t              theta2_reg;
    val_t              g2_reg;
    prod_t             pwd2_reg;
    // stage 3
    logic              v3_reg;
    logic [ADDR_W-1:0] a3_reg;
    val_t              theta3_reg;
    val_t              d3_reg;
    logic              vold3_reg;
    prod_t             pa3_reg;
    logic              clamp3_reg;
    // stage 4
    logic              v4_reg;
    logic [ADDR_W-1:0] a4_reg;
    val_t              theta4_reg;
    val_t              d4_reg;
    logic              vold4_reg;
    sval_t             ra4_reg;
    prod_t             pb4_reg;
    logic              clamp4_reg;

    logic              go2, go3, go4;
    logic              haz, adv1, accept;
    logic [EXT_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] addr_in;
    logic              dec_on, mom_on;
    sval_t             rwd, dsum;
    val_t              d2;
    logic              clamp2;
    prod_t             pa2;
    sval_t             ra3;
    logic signed [COEF_W:0] damp_scale;
    prod_t             pb3;
    sval_t             rb4, bsum;
    val_t              mbuf4;
    logic              clamp4;

    assign dec_on = (cfg.decay != '0);
    assign mom_on = (cfg.momentum != '0);

    // power-of-two store: index wraps by masking
    assign idx_ext = EXT_W'(item.element_index) & EXT_W'(MAX_ELEMENTS - 1);
    assign addr_in = idx_ext[ADDR_W-1:0];

    assign go4 = !v4_reg || upd_ready;
    assign go3 = !v3_reg || go4;
    assign go2 = !v2_reg || go3;

    // element still being updated further down: wait until its write is done
    assign haz = v1_reg && ((v2_reg && a2_reg == a1_reg) ||
                            (v3_reg && a3_reg == a1_reg) ||
                            (v4_reg && a4_reg == a1_reg));
    assign adv1 = v1_reg && go2 && !haz;

    assign item.ready = !hold && (!v1_reg || adv1);
    assign accept     = item.valid && item.ready;

    assign mem_re    = go2;
    assign mem_raddr = a1_reg;

    // stage 2: decayed gradient, old momentum product
    assign rwd    = round_sat(pwd2_reg);
    assign dsum   = add_sat(g2_reg, rwd.val, 1'b0);
    assign d2     = dec_on ? dsum.val : g2_reg;
    assign clamp2 = dec_on && (rwd.clamp || dsum.clamp);
    assign pa2    = coef_mul(cfg.momentum, val_t'(mem_rdata[VAL_W-1:0]));

    // stage 3
    assign ra3        = round_sat(pa3_reg);
    assign damp_scale = $signed({1'b0, COEF_ONE}) - $signed({1'b0, cfg.dampening});
    assign pb3        = damp_scale * d3_reg;

    // stage 4: new buffer
    assign rb4    = round_sat(pb4_reg);
    assign bsum   = add_sat(ra4_reg.val, rb4.val, 1'b0);
    assign mbuf4  = vold4_reg ? bsum.val : d4_reg;
    assign clamp4 = clamp4_reg ||
                    (mom_on && vold4_reg && (ra4_reg.clamp || rb4.clamp || bsum.clamp));

    assign mem_we    = v4_reg && upd_ready;
    assign mem_waddr = a4_reg;
    assign mem_wdata = mom_on ? {1'b1, mbuf4} : '0;

    assign upd_valid  = v4_reg;
    assign upd.theta  = theta4_reg;
    assign upd.d      = d4_reg;
    assign upd.mbuf   = mbuf4;
    assign upd.clamp  = clamp4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                v1_reg <= item.valid;
            if (go2)
                v2_reg <= adv1;
            if (go3)
                v3_reg <= v2_reg;
            if (go4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a1_reg     <= addr_in;
            theta1_reg <= item.param_value;
            g1_reg     <= item.grad_value;
        end
        if (go2)
        begin
            a2_reg     <= a1_reg;
            theta2_reg <= theta1_reg;
            g2_reg     <= g1_reg;
            pwd2_reg   <= coef_mul(cfg.decay, theta1_reg);
        end
        if (go3)
        begin
            a3_reg     <= a2_reg;
            theta3_reg <= theta2_reg;
            d3_reg     <= d2;
            vold3_reg  <= mem_rdata[VAL_W];
            pa3_reg    <= pa2;
            clamp3_reg <= clamp2;
        end
        if (go4)
        begin
            a4_reg     <= a3_reg;
            theta4_reg <= theta3_reg;
            d4_reg     <= d3_reg;
            vold4_reg  <= vold3_reg;
            ra4_reg    <= ra3;
            pb4_reg    <= pb3;
            clamp4_reg <= clamp3_reg;
        end
    end

    `SMU_ASSERT_NOW(a_rd_wr_apart, adv1 && mem_we, mem_waddr != a1_reg)
    `SMU_ASSERT_NEXT(a_rdata_held, v2_reg && !go3, $stable(mem_rdata))
    `SMU_ASSERT_NEXT(a_haz_holds, haz, v1_reg && $stable(a1_reg))
endmodule

// ===== src/smu_back.sv =====
// Stages 5-9: Nesterov correction, learning-rate step, output register
module smu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  smu_pkg::cfg_t cfg,
    input  logic          upd_valid,
    output logic          upd_ready,
    input  smu_pkg::upd_t upd,
    smu_out_if.source     result
);
    import smu_pkg::*;

    logic  v5_reg, v6_reg, v7_reg, v8_reg, vo_reg;
    val_t  theta5_reg, d5_reg, mbuf5_reg;
    logic  clamp5_reg;
    val_t  theta6_reg, d6_reg, mbuf6_reg;
    prod_t pn6_reg;
    logic  clamp6_reg;
    val_t  theta7_reg, de7_reg, mbuf7_reg;
    logic  clamp7_reg;
    val_t  theta8_reg, mbuf8_reg;
    prod_t plr8_reg;
    logic  clamp8_reg;
    val_t  new_param_reg, mom_out_reg;
    logic  sat_reg;

    logic  go5, go6, go7, go8, go_o;
    logic  mom_on;
    sval_t rn6, dn6, rl8, np8;
    val_t  de6;
    logic  clamp6, clamp8;

    assign mom_on = (cfg.momentum != '0);

    assign go_o = !vo_reg || result.ready;
    assign go8  = !v8_reg || go_o;
    assign go7  = !v7_reg || go8;
    assign go6  = !v6_reg || go7;
    assign go5  = !v5_reg || go6;
    assign upd_ready = go5;

    // stage 6: direction used for the step
    assign rn6    = round_sat(pn6_reg);
    assign dn6    = add_sat(d6_reg, rn6.val, 1'b0);
    assign de6    = !mom_on ? d6_reg : (cfg.nesterov ? dn6.val : mbuf6_reg);
    assign clamp6 = clamp6_reg || (mom_on && cfg.nesterov && (rn6.clamp || dn6.clamp));

    // stage 8: theta - lr*d
    assign rl8    = round_sat(plr8_reg);
    assign np8    = add_sat(theta8_reg, rl8.val, 1'b1);
    assign clamp8 = clamp8_reg || rl8.clamp || np8.clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (go5)
                v5_reg <= upd_valid;
            if (go6)
                v6_reg <= v5_reg;
            if (go7)
                v7_reg <= v6_reg;
            if (go8)
                v8_reg <= v7_reg;
            if (go_o)
                vo_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go5)
        begin
            theta5_reg <= upd.theta;
            d5_reg     <= upd.d;
            mbuf5_reg  <= upd.mbuf;
            clamp5_reg <= upd.clamp;
        end
        if (go6)
        begin
            theta6_reg <= theta5_reg;
            d6_reg     <= d5_reg;
            mbuf6_reg  <= mbuf5_reg;
            pn6_reg    <= coef_mul(cfg.momentum, mbuf5_reg);
            clamp6_reg <= clamp5_reg;
        end
        if (go7)
        begin
            theta7_reg <= theta6_reg;
            de7_reg    <= de6;
            mbuf7_reg  <= mbuf6_reg;
            clamp7_reg <= clamp6;
        end
        if (go8)
        begin
            theta8_reg <= theta7_reg;
            mbuf8_reg  <= mbuf7_reg;
            plr8_reg   <= coef_mul(cfg.learning_rate, de7_reg);
            clamp8_reg <= clamp7_reg;
        end
        if (go_o)
        begin
            new_param_reg <= np8.val;
            mom_out_reg   <= mom_on ? mbuf8_reg : '0;
            sat_reg       <= clamp8;
        end
    end

    assign result.valid        = vo_reg;
    assign result.new_param    = new_param_reg;
    assign result.momentum_out = mom_out_reg;
    assign result.saturated    = sat_reg;
endmodule

// ===== src/sgd_momentum_update_unit.sv =====
// Throughput: one request per cycle while the result side is ready; a request for an
// element that one of the three requests ahead of it is still updating waits in stage 1
// until that element's momentum write-back is done.
// Reset: config registers take their reset values and a clearing pass over all
// MAX_ELEMENTS entries (4096 by default) wipes the valid bits with item.ready low.
module sgd_momentum_update_unit #(
    parameter int unsigned MAX_ELEMENTS = smu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    smu_in_if.sink                         item,
    smu_out_if.source                      result,
    input  logic                           cfg_wr_en,
    input  logic [smu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import smu_pkg::*;

    localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    cfg_t              cfg_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic              f_we, m_we, m_re;
    logic [ADDR_W-1:0] f_waddr, m_waddr, m_raddr;
    logic [MEM_W-1:0]  f_wdata, m_wdata, m_rdata;
    logic              upd_valid, upd_ready;
    upd_t              upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate <= LR_RESET;
            cfg_reg.decay         <= '0;
            cfg_reg.momentum      <= '0;
            cfg_reg.dampening     <= '0;
            cfg_reg.nesterov      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LEARNING_RATE: cfg_reg.learning_rate <= cfg_wdata;
                REG_DECAY:         cfg_reg.decay         <= cfg_wdata;
                REG_MOMENTUM:      cfg_reg.momentum      <= cfg_wdata;
                REG_DAMPENING:     cfg_reg.dampening     <= cfg_wdata;
                REG_NESTEROV:      cfg_reg.nesterov      <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // clearing pass over the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == ADDR_W'(MAX_ELEMENTS - 1))
                clr_busy_reg <= 1'b0;
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign m_we    = clr_busy_reg || f_we;
    assign m_waddr = clr_busy_reg ? clr_cnt_reg : f_waddr;
    assign m_wdata = clr_busy_reg ? '0 : f_wdata;

    smu_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    smu_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .hold      (clr_busy_reg),
        .item      (item),
        .mem_re    (m_re),
        .mem_raddr (m_raddr),
        .mem_rdata (m_rdata),
        .mem_we    (f_we),
        .mem_waddr (f_waddr),
        .mem_wdata (f_wdata),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd       (upd)
    );

    smu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd       (upd),
        .result    (result)
    );
endmodule

// ===== bench/sgd_momentum_update_unit_tb.sv =====
// Self-checking testbench for the SGD momentum update unit
`timescale 1ns / 100ps

module sgd_momentum_update_unit_tb;
    import smu_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;
    localparam val_t Q_ONE     = 32'sh0001_0000;
    localparam coef_t COEF_ALL = '1;

    // Tracks the coefficients and per-element momentum, predicts every update
    class param_update_ledger;
        typedef struct {
            val_t new_param;
            val_t momentum;
            logic saturated;
        } update_t;

        cfg_t    regs;
        val_t    momentum_mem [MAX_ELEMENTS_DEF];
        bit      momentum_live [MAX_ELEMENTS_DEF];
        update_t expected_updates [$];
        int      mismatches;
        bit      clamped;

        function new();
            regs = '0;
            regs.learning_rate = LR_RESET;
            mismatches = 0;
            foreach (momentum_live[i])
                momentum_live[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LEARNING_RATE: regs.learning_rate = data;
                REG_DECAY:         regs.decay = data;
                REG_MOMENTUM:      regs.momentum = data;
                REG_DAMPENING:     regs.dampening = data;
                REG_NESTEROV:      regs.nesterov = data[0];
                default:           ;
            endcase
        endfunction

        function longint clamp_to_range(longint x);
            if (x > longint'(VAL_MAX))
            begin
                clamped = 1'b1;
                return longint'(VAL_MAX);
            end
            if (x < longint'(VAL_MIN))
            begin
                clamped = 1'b1;
                return longint'(VAL_MIN);
            end
            return x;
        endfunction

        // coef/65536 * v, nearest with ties up (floor after adding half)
        function longint scale(longint coef, longint v);
            return clamp_to_range((coef * v + (longint'(1) <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT);
        endfunction

        function void note_request(logic [IDX_W-1:0] idx, val_t param, val_t grad);
            longint theta;
            longint step;
            longint buffer;
            update_t upd;
            theta = param;
            step = grad;
            clamped = 1'b0;
            upd.momentum = '0;
            if (regs.decay != 0)
                step = clamp_to_range(step + scale(longint'(regs.decay), theta));
            if (regs.momentum != 0)
            begin
                if (!momentum_live[idx])
                    buffer = step;
                else
                    buffer = clamp_to_range(
                        scale(longint'(regs.momentum), longint'(momentum_mem[idx])) +
                        scale(longint'(COEF_ONE) - longint'(regs.dampening), step));
                momentum_mem[idx] = val_t'(buffer);
                momentum_live[idx] = 1'b1;
                upd.momentum = val_t'(buffer);
                if (regs.nesterov)
                    step = clamp_to_range(step + scale(longint'(regs.momentum), buffer));
                else
                    step = buffer;
            end
            else
            begin
                momentum_live[idx] = 1'b0;
            end
            theta = clamp_to_range(theta - scale(longint'(regs.learning_rate), step));
            upd.new_param = val_t'(theta);
            upd.saturated = clamped;
            expected_updates.push_back(upd);
        endfunction

        function void check_result(val_t new_param, val_t momentum, logic saturated);
            update_t want;
            if (expected_updates.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d / %0d / %0b",
                         $time, new_param, momentum, saturated);
                mismatches++;
                return;
            end
            want = expected_updates.pop_front();
            if (new_param !== want.new_param)
            begin
                $display("%0t: new_param: expected %0d, actual %0d",
                         $time, want.new_param, new_param);
                mismatches++;
            end
            if (momentum !== want.momentum)
            begin
                $display("%0t: momentum_out: expected %0d, actual %0d",
                         $time, want.momentum, momentum);
                mismatches++;
            end
            if (saturated !== want.saturated)
            begin
                $display("%0t: saturated: expected %0b, actual %0b",
                         $time, want.saturated, saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    smu_in_if  item_bus ();
    smu_out_if result_bus ();

    param_update_ledger ledger;

    bit hold_request;
    bit steady_sender;
    bit quiet_tail;
    int sender_run_left;
    int result_stall_left;
    int result_run_left;
    int quiet_cycles = 0;

    sgd_momentum_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus.sink),
        .result    (result_bus.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (result_bus.valid && result_bus.ready)
            ledger.check_result(result_bus.new_param, result_bus.momentum_out,
                                result_bus.saturated);
        if (cfg_wr_en)
            ledger.write_reg(cfg_index, cfg_wdata);
        if (item_bus.valid && item_bus.ready)
            ledger.note_request(item_bus.element_index, item_bus.param_value,
                                item_bus.grad_value);
    end

    // no request or result moving for too long
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall_left = HOLD_CYCLES;
            end
            if (result_stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                result_stall_left--;
            end
            else if (quiet_tail || result_run_left > 0)
            begin
                result_bus.ready <= 1'b1;
                if (result_run_left > 0)
                    result_run_left--;
            end
            else
            begin
                result_bus.ready <= 1'b0;
                result_stall_left = $urandom_range(1, 12) - 1;
                result_run_left = $urandom_range(0, 30);
            end
        end
    end

    task automatic send_request(input logic [IDX_W-1:0] idx, input val_t param,
                                input val_t grad);
        int gap;
        if (!steady_sender && !quiet_tail)
        begin
            if (sender_run_left > 0)
                sender_run_left--;
            else
            begin
                gap = $urandom_range(1, 12);
                sender_run_left = $urandom_range(0, 20);
                item_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        item_bus.valid <= 1'b1;
        item_bus.element_index <= idx;
        item_bus.param_value <= param;
        item_bus.grad_value <= grad;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    // drains the pipeline first; unused indexes get junk that must be ignored
    task automatic apply_settings(input coef_t lr, input coef_t wd, input coef_t mom,
                                  input coef_t damp, input logic nest);
        item_bus.valid <= 1'b0;
        while (ledger.expected_updates.size() != 0)
            @(negedge clk);
        for (int i = REG_NESTEROV + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
        write_reg(REG_LEARNING_RATE, lr);
        write_reg(REG_DECAY, wd);
        write_reg(REG_MOMENTUM, mom);
        write_reg(REG_DAMPENING, damp);
        write_reg(REG_NESTEROV, CFG_DATA_W'(nest));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic val_t random_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3, 4:    return val_t'($urandom);
            default: return val_t'($urandom_range(0, 2 ** 20)) - val_t'(2 ** 19);
        endcase
    endfunction

    // mostly a handful of elements so momentum chains build and hazards occur
    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return IDX_W'($urandom);
            1:       return '1;
            2, 3:    return IDX_W'($urandom_range(8, 63));
            default: return IDX_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic coef_t pick_coef(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return COEF_ALL;
            3:       return coef_t'($urandom);
            default: return coef_t'($urandom_range(lo, hi));
        endcase
    endfunction

    initial
    begin
        coef_t lr;
        coef_t wd;
        coef_t mom;
        coef_t damp;
        ledger = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        item_bus.valid = 1'b0;
        item_bus.element_index = '0;
        item_bus.param_value = '0;
        item_bus.grad_value = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients, momentum off
        send_request(12'd0, VAL_MAX, VAL_MAX);
        send_request(12'd1, VAL_MIN, VAL_MIN);
        send_request(12'd2, VAL_MAX, VAL_MIN);
        send_request(12'd3, VAL_MIN, VAL_MAX);
        send_request('1, '0, '0);

        // unity coefficients: first use, then a read of the stored momentum
        apply_settings(COEF_ONE, COEF_ONE, COEF_ONE, '0, 1'b0);
        send_request(12'd5, Q_ONE, Q_ONE);
        send_request(12'd5, Q_ONE, -Q_ONE);
        send_request(12'd5, VAL_MAX, VAL_MAX);
        send_request(12'd6, VAL_MIN, 32'sd1);

        // coefficients above one, Nesterov; dampening flips the new gradient
        apply_settings(COEF_ALL, COEF_ALL, COEF_ALL, COEF_ALL, 1'b1);
        send_request(12'd6, Q_ONE, Q_ONE);
        send_request(12'd5, -Q_ONE, Q_ONE);
        send_request(12'd7, Q_ONE, -Q_ONE);
        send_request(12'd7, 32'sd3, -32'sd5);

        // momentum off drops the element's history
        apply_settings(coef_t'(6554), coef_t'(655), '0, '0, 1'b1);
        send_request(12'd5, Q_ONE, Q_ONE);

        // momentum back on: element 5 starts over from its gradient
        apply_settings('0, '0, coef_t'(58982), '0, 1'b0);
        send_request(12'd5, Q_ONE, Q_ONE);
        send_request(12'd5, Q_ONE, -Q_ONE);
        send_request(12'd0, VAL_MIN, Q_ONE);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                apply_settings(COEF_ALL, COEF_ALL, COEF_ALL, COEF_ALL, 1'b1);
            else if (p == 1)
                apply_settings('0, '0, coef_t'(1), COEF_ONE, 1'b0);
            else
            begin
                lr = pick_coef(1, 6554);
                wd = ($urandom_range(0, 1) == 0) ? coef_t'(0) : pick_coef(1, 3277);
                mom = pick_coef(49152, 65536);
                damp = ($urandom_range(0, 1) == 0) ? coef_t'(0) : pick_coef(0, 16384);
                apply_settings(lr, wd, mom, damp, 1'($urandom_range(0, 1)));
            end
            // long result hold with a steady sender: fills the pipe, stalls input
            if (p == 3)
            begin
                steady_sender = 1'b1;
                hold_request = 1'b1;
            end
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_index(), random_value(), random_value());
            steady_sender = 1'b0;
        end

        item_bus.valid <= 1'b0;
        while (ledger.expected_updates.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (ledger.mismatches == 0 && ledger.expected_updates.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
